FILE: hw/rtl/imu_midpoint_pose_integrator_defines.svh
// Assertion helpers for the pose integrator.
`ifndef IMU_MIDPOINT_POSE_INTEGRATOR_DEFINES_SVH
`define IMU_MIDPOINT_POSE_INTEGRATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/imupi_pkg.sv
package imupi_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int STATE_BITS_DEF  = 32;
    localparam int DT_BITS         = 24;
    localparam int ADDR_W          = 5;
    localparam int ONE_Q30         = 1 << 30;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_AB_X = 3'd0;
    localparam logic [2:0] REG_AB_Y = 3'd1;
    localparam logic [2:0] REG_AB_Z = 3'd2;
    localparam logic [2:0] REG_GB_X = 3'd3;
    localparam logic [2:0] REG_GB_Y = 3'd4;
    localparam logic [2:0] REG_GB_Z = 3'd5;

    // operand pairs of the h*h products: xx yy zz xy xz yz
    localparam logic [1:0] HH_A [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam logic [1:0] HH_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef enum logic [5:0] {
        P_H   = 6'b000001,
        P_U0  = 6'b000010,
        P_HH  = 6'b000100,
        P_RN  = 6'b001000,
        P_U1  = 6'b010000,
        P_FIN = 6'b100000
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] a;
        logic [1:0] b;
        logic [2:0] k;
    } t_tag;

endpackage

FILE: hw/rtl/imu_midpoint_pose_integrator.sv
// IMU midpoint pose integrator.
// Input channel (i_valid/o_ready): one IMU sample per transfer: kind, step time,
// three-axis acceleration and angular rate. Output channel (o_valid/i_ready): one
// result per sample, the position and velocity after that sample.
// An integrate sample runs 63 steps through one shared signed multiplier: the
// rotation half-angle, R_old*a0, the h*h terms, R*dR, R_new*a1, then position and
// velocity per axis. One product issues per cycle and retires the next cycle;
// a latch-only sample answers in the next cycle. The block takes one sample at
// a time: o_ready is high only when no result is pending, so none is taken
// before the result is transferred. When the receiver stalls, the result holds
// on the output until transferred. Reset (synchronous, i_rst_n low) sets
// orientation to identity, position, velocity, previous sample and biases to
// zero and clears the primed flag. Biases are written over the APB port; the
// user must do so only while the block is idle, which it does not enforce.
`include "imu_midpoint_pose_integrator_defines.svh"

module imu_midpoint_pose_integrator
    import imupi_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [DT_BITS-1:0]            i_step_time,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [SAMPLE_BITS-1:0] i_rate_x,
    input  logic signed [SAMPLE_BITS-1:0] i_rate_y,
    input  logic signed [SAMPLE_BITS-1:0] i_rate_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [STATE_BITS-1:0]  o_pos_x,
    output logic signed [STATE_BITS-1:0]  o_pos_y,
    output logic signed [STATE_BITS-1:0]  o_pos_z,
    output logic signed [STATE_BITS-1:0]  o_vel_x,
    output logic signed [STATE_BITS-1:0]  o_vel_y,
    output logic signed [STATE_BITS-1:0]  o_vel_z,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int S   = SAMPLE_BITS;
    localparam int WA0 = (S + 14 > STATE_BITS) ? S + 14 : STATE_BITS;
    localparam int WA  = (WA0 > 32) ? WA0 : 32;         // multiplier operand A
    localparam int WB  = (S + 1 > 32) ? S + 1 : 32;     // multiplier operand B
    localparam int WP  = WA + WB;                       // product / accumulator
    localparam int WU  = S + 5;                         // rotated acceleration
    localparam int WS  = S + 6;                         // sum of both ends
    localparam int WDU = S + 14;                        // dt*u

    function automatic logic signed [WP-1:0] rnd(input logic signed [WP-1:0] x,
                                                 input int n);
        rnd = (x + (WP'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [WP-1:0] sat_n(input logic signed [WP-1:0] x,
                                                   input int bits);
        logic signed [WP-1:0] hi;
        logic signed [WP-1:0] lo;
        hi = (WP'(1) <<< (bits - 1)) - WP'(1);
        lo = -hi - WP'(1);
        sat_n = (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;
    t_phase r_phase;
    logic [1:0] r_ca, r_cb;
    logic [2:0] r_ck;
    logic       r_rt_vld;
    t_tag       r_tag;
    logic       r_primed;

    logic signed [S-1:0]          r_ab [3];
    logic signed [S-1:0]          r_gb [3];
    logic signed [S-1:0]          r_prev_acc [3];
    logic signed [S-1:0]          r_prev_rate [3];
    logic signed [S-1:0]          r_acc [3];
    logic signed [S-1:0]          r_rate [3];
    logic [DT_BITS-1:0]           r_dt;
    logic signed [31:0]           r_orient [9];
    logic signed [STATE_BITS-1:0] r_pos [3];
    logic signed [STATE_BITS-1:0] r_vel [3];

    // working registers of one item
    logic signed [31:0]  r_h [3];
    logic signed [34:0]  r_hh [6];
    logic signed [WU-1:0] r_u0 [3];
    logic signed [WU-1:0] r_u1 [3];
    logic signed [WP-1:0] r_prod, r_sum, r_vn, r_pacc;
    logic signed [31:0]  r_rn [2];
    logic signed [WDU-1:0] r_du;

    // ------------------------------------------------------------ handshake
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign pready  = 1'b1;

    logic in_xfer, cfg_wr;
    logic [2:0] cfg_idx;
    assign in_xfer = i_valid && o_ready;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb begin
        case (cfg_idx)
            REG_AB_X: prdata = 32'(r_ab[0]);
            REG_AB_Y: prdata = 32'(r_ab[1]);
            REG_AB_Z: prdata = 32'(r_ab[2]);
            REG_GB_X: prdata = 32'(r_gb[0]);
            REG_GB_Y: prdata = 32'(r_gb[1]);
            REG_GB_Z: prdata = 32'(r_gb[2]);
            default: prdata = '0;
        endcase
    end

    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];
    assign o_vel_x = r_vel[0];
    assign o_vel_y = r_vel[1];
    assign o_vel_z = r_vel[2];

    // ---------------------------------------------------- derived operands
    logic signed [S+1:0]   rs [3];   // prev_rate + rate - 2*gyro_bias
    logic signed [S:0]     a0 [3];
    logic signed [S:0]     a1 [3];
    logic signed [WS-1:0]  us [3];
    logic signed [WP-1:0]  dw [9];
    logic signed [31:0]    d [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rs[i] = (S + 2)'(r_prev_rate[i]) + (S + 2)'(r_rate[i])
                  - ((S + 2)'(r_gb[i]) <<< 1);
            a0[i] = (S + 1)'(r_prev_acc[i]) - (S + 1)'(r_ab[i]);
            a1[i] = (S + 1)'(r_acc[i]) - (S + 1)'(r_ab[i]);
            us[i] = WS'(r_u0[i]) + WS'(r_u1[i]);
        end
        // small-angle rotation of the unnormalized quaternion (1, h)
        dw[0] = WP'(ONE_Q30) - WP'(r_hh[1]) - WP'(r_hh[2]);
        dw[1] = WP'(r_hh[3]) - (WP'(r_h[2]) <<< 1);
        dw[2] = WP'(r_hh[4]) + (WP'(r_h[1]) <<< 1);
        dw[3] = WP'(r_hh[3]) + (WP'(r_h[2]) <<< 1);
        dw[4] = WP'(ONE_Q30) - WP'(r_hh[0]) - WP'(r_hh[2]);
        dw[5] = WP'(r_hh[5]) - (WP'(r_h[0]) <<< 1);
        dw[6] = WP'(r_hh[4]) - (WP'(r_h[1]) <<< 1);
        dw[7] = WP'(r_hh[5]) + (WP'(r_h[0]) <<< 1);
        dw[8] = WP'(ONE_Q30) - WP'(r_hh[0]) - WP'(r_hh[1]);
        for (int i = 0; i < 9; i++) begin
            d[i] = 32'(sat_n(dw[i], 32));
        end
    end

    // ------------------------------------------------------------ issue
    logic [3:0] oi, di;
    logic signed [WA-1:0] opa;
    logic signed [WB-1:0] opb, dtb;
    logic signed [WP-1:0] mul;

    assign oi  = (r_phase == P_RN) ? 4'(3 * r_ca + r_ck) : 4'(3 * r_cb + r_ck);
    assign di  = 4'(3 * r_ck + r_cb);
    assign dtb = WB'($signed({1'b0, r_dt}));

    always_comb begin
        opa = '0;
        opb = dtb;
        case (r_phase)
            P_H: opa = WA'(rs[r_ck[1:0]]);
            P_U0: begin
                opa = WA'(r_orient[oi]);
                opb = WB'(a0[r_ck[1:0]]);
            end
            P_HH: begin
                opa = WA'(r_h[HH_A[r_ck]]);
                opb = WB'(r_h[HH_B[r_ck]]);
            end
            P_RN: begin
                opa = WA'(r_orient[oi]);
                opb = WB'(d[di]);
            end
            P_U1: begin
                opa = WA'(r_orient[oi]);
                opb = WB'(a1[r_ck[1:0]]);
            end
            P_FIN: begin
                case (r_ck)
                    3'd0: opa = WA'(us[r_cb]);
                    3'd1: opa = WA'(r_vel[r_cb]);
                    default: opa = WA'(r_du);
                endcase
            end
            default: opa = '0;
        endcase
    end

    assign mul = opa * opb;

    // loop bounds per phase
    logic [2:0] klim;
    logic [1:0] blim, alim;
    t_phase     nxt_phase;
    logic       last_issue;

    always_comb begin
        klim = 3'd2;
        blim = 2'd2;
        alim = 2'd0;
        nxt_phase = P_H;
        case (r_phase)
            P_H: begin
                blim = 2'd0;
                nxt_phase = P_U0;
            end
            P_U0: nxt_phase = P_HH;
            P_HH: begin
                klim = 3'd5;
                blim = 2'd0;
                nxt_phase = P_RN;
            end
            P_RN: begin
                alim = 2'd2;
                nxt_phase = P_U1;
            end
            P_U1: nxt_phase = P_FIN;
            P_FIN: nxt_phase = P_H;
            default: nxt_phase = P_H;
        endcase
    end

    assign last_issue = (r_phase == P_FIN) && (r_cb == 2'd2) && (r_ck == 3'd2);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_kind ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------ retire
    logic signed [WP-1:0] rt_t, rt_sum, rt_sat;
    always_comb begin
        rt_t   = (r_tag.phase == P_RN) ? rnd(r_prod, 30) : r_prod;
        rt_sum = (r_tag.k == 3'd0) ? rt_t : r_sum + rt_t;
        rt_sat = sat_n(rt_sum, 32);
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= P_H;
            r_ca     <= '0;
            r_cb     <= '0;
            r_ck     <= '0;
            r_rt_vld <= 1'b0;
            r_primed <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_ab[i]        <= '0;
                r_gb[i]        <= '0;
                r_prev_acc[i]  <= '0;
                r_prev_rate[i] <= '0;
                r_pos[i]       <= '0;
                r_vel[i]       <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_orient[i] <= (i % 4 == 0) ? 32'(ONE_Q30) : '0;
            end
        end else begin
            r_state  <= n_state;
            r_rt_vld <= (r_state == S_RUN);

            if (cfg_wr) begin
                case (cfg_idx)
                    REG_AB_X: r_ab[0] <= pwdata[S-1:0];
                    REG_AB_Y: r_ab[1] <= pwdata[S-1:0];
                    REG_AB_Z: r_ab[2] <= pwdata[S-1:0];
                    REG_GB_X: r_gb[0] <= pwdata[S-1:0];
                    REG_GB_Y: r_gb[1] <= pwdata[S-1:0];
                    REG_GB_Z: r_gb[2] <= pwdata[S-1:0];
                    default: ;
                endcase
            end

            // prime on the first sample, latch only on kind 1
            if (in_xfer) begin
                r_primed <= 1'b1;
                if (i_kind || !r_primed) begin
                    r_prev_acc  <= '{i_accel_x, i_accel_y, i_accel_z};
                    r_prev_rate <= '{i_rate_x, i_rate_y, i_rate_z};
                end
                r_phase <= P_H;
                r_ca    <= '0;
                r_cb    <= '0;
                r_ck    <= '0;
            end

            // advance the loop counters
            if (r_state == S_RUN) begin
                if (r_ck != klim) begin
                    r_ck <= r_ck + 3'd1;
                end else begin
                    r_ck <= '0;
                    if (r_cb != blim) begin
                        r_cb <= r_cb + 2'd1;
                    end else begin
                        r_cb <= '0;
                        if (r_ca != alim) begin
                            r_ca <= r_ca + 2'd1;
                        end else begin
                            r_ca    <= '0;
                            r_phase <= nxt_phase;
                        end
                    end
                end
            end

            if (r_state == S_DRAIN) begin
                r_prev_acc  <= r_acc;
                r_prev_rate <= r_rate;
            end

            if (r_rt_vld) begin
                // write back a full row of R*dR once its last entry is done
                if (r_tag.phase == P_RN && r_tag.k == 3'd2 && r_tag.b == 2'd2) begin
                    r_orient[3 * r_tag.a]     <= r_rn[0];
                    r_orient[3 * r_tag.a + 1] <= r_rn[1];
                    r_orient[3 * r_tag.a + 2] <= 32'(rt_sat);
                end
                if (r_tag.phase == P_FIN && r_tag.k == 3'd2) begin
                    r_pos[r_tag.b] <= STATE_BITS'(sat_n(r_pacc + rnd(r_prod, 33),
                                                        STATE_BITS));
                    r_vel[r_tag.b] <= STATE_BITS'(sat_n(r_vn, STATE_BITS));
                end
            end
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dt   <= i_step_time;
            r_acc  <= '{i_accel_x, i_accel_y, i_accel_z};
            r_rate <= '{i_rate_x, i_rate_y, i_rate_z};
        end
        r_prod <= mul;
        r_tag  <= '{phase: r_phase, a: r_ca, b: r_cb, k: r_ck};
        if (r_rt_vld) begin
            case (r_tag.phase)
                P_H: r_h[r_tag.k[1:0]] <= 32'(sat_n(rnd(r_prod, 12), 32));
                P_U0: begin
                    r_sum <= rt_sum;
                    if (r_tag.k == 3'd2) begin
                        r_u0[r_tag.b] <= WU'(rnd(rt_sum, 30));
                    end
                end
                P_HH: r_hh[r_tag.k] <= 35'(rnd(r_prod, 29));
                P_RN: begin
                    r_sum <= rt_sum;
                    if (r_tag.k == 3'd2 && r_tag.b != 2'd2) begin
                        r_rn[r_tag.b[0]] <= 32'(rt_sat);
                    end
                end
                P_U1: begin
                    r_sum <= rt_sum;
                    if (r_tag.k == 3'd2) begin
                        r_u1[r_tag.b] <= WU'(rnd(rt_sum, 30));
                    end
                end
                P_FIN: begin
                    if (r_tag.k == 3'd0) begin
                        r_du <= WDU'(rnd(r_prod, 17));
                        r_vn <= WP'(r_vel[r_tag.b]) + rnd(r_prod, 25);
                    end else if (r_tag.k == 3'd1) begin
                        r_pacc <= WP'(r_pos[r_tag.b]) + rnd(r_prod, 24);
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ checks
    `ASSERT_IMPLY(a_ready_excl, i_clk, i_rst_n, o_ready, !o_valid)
    `ASSERT_NEXT(a_latch_only, i_clk, i_rst_n, in_xfer && i_kind, o_valid)
    `ASSERT_NEXT(a_integrate, i_clk, i_rst_n, in_xfer && !i_kind, r_state == S_RUN)
    `ASSERT_IMPLY(a_drain_retire, i_clk, i_rst_n, r_state == S_DRAIN, r_rt_vld)
    `ASSERT_NEXT(a_primed, i_clk, i_rst_n, in_xfer, r_primed)
    `ASSERT_NEXT(a_out_done, i_clk, i_rst_n, o_valid && i_ready, o_ready)

endmodule
